[hdl/magd_pkg.sv]
// Shared types, register indexes and copy-offset tables for the MAG image decoder.
// No dependencies; imported by the decoder top level, the checker and the testbench.
package magd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_COLOR_MODE = 2'd0,
    CFG_X_START    = 2'd1,
    CFG_X_END      = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [9:0] XStartRst = 10'd0;
  localparam logic [9:0] XEndRst   = 10'd639;

  // Nibble phase of a flag column: high nibble first
  typedef enum logic {
    PH_HIGH = 1'b0,
    PH_LOW  = 1'b1
  } nib_phase_e;

  // Horizontal copy distance in units for each nonzero flag nibble
  function automatic logic [2:0] back_units(input logic [3:0] nib);
    logic [2:0] res;
    case (nib)
      4'd1, 4'd5, 4'd7, 4'd10, 4'd13: res = 3'd1;
      4'd2, 4'd8, 4'd11, 4'd14:       res = 3'd2;
      4'd3:                           res = 3'd4;
      default:                        res = 3'd0;
    endcase
    return res;
  endfunction

  // Vertical copy distance in rows for each flag nibble
  function automatic logic [4:0] back_rows(input logic [3:0] nib);
    logic [4:0] res;
    case (nib)
      4'd4, 4'd5:         res = 5'd1;
      4'd6, 4'd7, 4'd8:   res = 5'd2;
      4'd9, 4'd10, 4'd11: res = 5'd4;
      4'd12, 4'd13, 4'd14: res = 5'd8;
      4'd15:              res = 5'd16;
      default:            res = 5'd0;
    endcase
    return res;
  endfunction

endpackage

[hdl/mag_image_flag_copy_decoder.sv]
// Top level of the MAG pixel decoder: flag row update, copy address logic, history pipeline.
// Depends on magd_pkg, magd_flag_mem and magd_hist_mem.
//
//  channel | signals                                         | dir | handshake
//  cfg     | cfg_we_i cfg_idx_i cfg_wdata_i                  | in  | write enable only
//  in      | image_first flag_a_bit flag_b_byte literal_win  | in  | in_valid_i/in_ready_o
//  out     | pixel_units literal_bytes_used row_end          | out | out_valid_o/out_ready_i
//
// Each of the two nibbles of a transaction takes one slot of the single history
// read port. A result passes the flag, read and data stages into the output register.
// The history clears logically through per-row fill counts, so reset and image
// start need no clearing pass. An output stall freezes the pipeline; one more
// input transaction is still taken into the input stage.
module mag_image_flag_copy_decoder #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned HISTORY_ROWS = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [magd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [magd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          image_first_i,
  input  logic                          flag_a_bit_i,
  input  logic [7:0]                    flag_b_byte_i,
  input  logic [31:0]                   literal_window_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   pixel_units_o,
  output logic [2:0]                    literal_bytes_used_o,
  output logic                          row_end_o
);
  import magd_pkg::*;

  localparam int unsigned ColsMax   = MAX_WIDTH / 4;
  localparam int unsigned UnitsMax  = MAX_WIDTH / 2;
  localparam int unsigned CW        = (ColsMax > 1) ? $clog2(ColsMax) : 1;
  localparam int unsigned UW        = CW + 1;
  localparam int unsigned SW        = $clog2(HISTORY_ROWS);
  localparam int unsigned FW        = UW + 1;
  localparam int unsigned HistAw    = SW + UW;
  localparam int unsigned HistDepth = HISTORY_ROWS * (2 ** UW);

  // One nibble operation travelling through the history pipeline
  typedef struct packed {
    logic          last;
    logic          clr;
    logic          lit;
    logic [3:0]    nib;
    logic [UW-1:0] unit;
    logic [SW-1:0] slot;
    logic [9:0]    upr;
    logic [15:0]   lit_val;
    logic [2:0]    used;
    logic          row_done;
  } hop_t;

  // ---------------------------------------------------------------------------
  // Configuration registers and row geometry
  logic       mode_q;
  logic [9:0] xs_q, xe_q;
  logic [6:0] grp_m1;
  logic [7:0] groups;
  logic [10:0] width_raw, width_sat;
  logic [8:0] cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      xs_q   <= XStartRst;
      xe_q   <= XEndRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLOR_MODE: mode_q <= cfg_wdata_i[0];
        CFG_X_START:    xs_q   <= cfg_wdata_i;
        CFG_X_END:      xe_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    grp_m1    = xe_q[9:3] - xs_q[9:3];
    groups    = {1'b0, grp_m1} + 8'd1;
    width_raw = {groups, 3'b000};
    width_sat = (32'(width_raw) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_raw;
    cols      = mode_q ? width_sat[10:2] : {1'b0, width_sat[10:3]};
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable: everything past the input stage holds while a result waits
  logic out_valid_q;
  logic en;
  assign en = !(out_valid_q && !out_ready_i);

  // ---------------------------------------------------------------------------
  // Input stage: column/slot selection and flag read
  logic        f_valid_q, f_first_q, f_a_q;
  logic [7:0]  f_b_q;
  logic [31:0] f_win_q;
  logic [CW-1:0] col_q, f_col_base, f_col, f_col_next;
  logic [SW-1:0] slot_q, f_slot, f_slot_next;
  logic          f_row_done;
  logic          f_move, in_acc;

  logic          x_valid_q;
  nib_phase_e    x_phase_q;

  assign f_move     = en && f_valid_q && (!x_valid_q || (x_phase_q == PH_LOW));
  assign in_ready_o = !f_valid_q || f_move;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    f_col_base = f_first_q ? '0 : col_q;
    f_slot     = f_first_q ? '0 : slot_q;
    if ((32'(f_col_base) >= 32'(cols)) || (32'(f_col_base) >= ColsMax)) begin
      f_col = '0;
    end else begin
      f_col = f_col_base;
    end
    f_row_done = (32'(f_col) + 32'd1) >= 32'(cols);
    if (f_row_done) begin
      f_col_next  = '0;
      f_slot_next = (32'(f_slot) == HISTORY_ROWS - 1) ? '0 : f_slot + SW'(1);
    end else begin
      f_col_next  = f_col + CW'(1);
      f_slot_next = f_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      col_q     <= '0;
      slot_q    <= '0;
    end else begin
      if (in_acc) begin
        f_valid_q <= 1'b1;
      end else if (f_move) begin
        f_valid_q <= 1'b0;
      end
      if (f_move) begin
        col_q  <= f_col_next;
        slot_q <= f_slot_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      f_first_q <= image_first_i;
      f_a_q     <= flag_a_bit_i;
      f_b_q     <= flag_b_byte_i;
      f_win_q   <= literal_window_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Flag stage: apply flag B byte, then issue one nibble per cycle unless an output stall holds
  logic          x_first_q, x_a_q, x_row_done_q;
  logic [7:0]    x_b_q, x_flag_q, flag_rd, flag_now;
  logic [31:0]   x_win_q;
  logic [CW-1:0] x_col_q;
  logic [SW-1:0] x_slot_q;
  logic [9:0]    x_upr_q;
  logic          flag_wr_en;
  logic          hi_zero, lo_zero;
  hop_t          x_op;

  magd_flag_mem #(
    .Depth(ColsMax),
    .AddrW(CW)
  ) u_flag_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (f_move && f_first_q),
    .rd_en_i  (f_move),
    .rd_addr_i(f_col),
    .rd_data_o(flag_rd),
    .wr_en_i  (flag_wr_en),
    .wr_addr_i(x_col_q),
    .wr_data_i(flag_now)
  );

  always_comb begin
    flag_now   = (x_phase_q == PH_HIGH) ? (flag_rd ^ (x_a_q ? x_b_q : 8'h00)) : x_flag_q;
    flag_wr_en = en && x_valid_q && (x_phase_q == PH_HIGH);
    hi_zero    = (flag_now[7:4] == 4'h0);
    lo_zero    = (flag_now[3:0] == 4'h0);

    x_op.upr      = x_upr_q;
    x_op.slot     = x_slot_q;
    x_op.row_done = x_row_done_q;
    x_op.used     = (hi_zero ? 3'd2 : 3'd0) + (lo_zero ? 3'd2 : 3'd0);
    if (x_phase_q == PH_HIGH) begin
      x_op.last    = 1'b0;
      x_op.clr     = x_first_q;
      x_op.lit     = hi_zero;
      x_op.nib     = flag_now[7:4];
      x_op.unit    = {x_col_q, 1'b0};
      x_op.lit_val = x_win_q[31:16];
    end else begin
      x_op.last    = 1'b1;
      x_op.clr     = 1'b0;
      x_op.lit     = lo_zero;
      x_op.nib     = flag_now[3:0];
      x_op.unit    = {x_col_q, 1'b1};
      x_op.lit_val = hi_zero ? x_win_q[15:0] : x_win_q[31:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
      x_phase_q <= PH_HIGH;
    end else if (en) begin
      if (x_valid_q && (x_phase_q == PH_HIGH)) begin
        x_phase_q <= PH_LOW;
      end else begin
        x_valid_q <= f_move;
        x_phase_q <= PH_HIGH;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_move) begin
      x_first_q    <= f_first_q;
      x_a_q        <= f_a_q;
      x_b_q        <= f_b_q;
      x_win_q      <= f_win_q;
      x_col_q      <= f_col;
      x_slot_q     <= f_slot;
      x_upr_q      <= {cols, 1'b0};
      x_row_done_q <= f_row_done;
    end
    if (flag_wr_en) begin
      x_flag_q <= flag_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage: copy source address
  logic          r_valid_q;
  hop_t          r_op_q;
  logic [4:0]    r_dy;
  logic [2:0]    r_dx;
  logic [11:0]   r_u, r_us;
  logic [5:0]    r_rows;
  logic          r_two;
  logic [SW-1:0] r_src_slot;

  always_comb begin
    r_dy  = back_rows(r_op_q.nib);
    r_dx  = back_units(r_op_q.nib);
    r_u   = 12'(r_op_q.unit);
    r_two = 1'b0;
    if (12'(r_dx) > r_u) begin
      // source wraps into earlier rows
      r_two  = (12'(r_dx) - r_u) > 12'(r_op_q.upr);
      r_rows = 6'(r_dy) + (r_two ? 6'd2 : 6'd1);
      r_us   = r_u + (r_two ? {1'b0, r_op_q.upr, 1'b0} : 12'(r_op_q.upr)) - 12'(r_dx);
    end else begin
      r_rows = 6'(r_dy);
      r_us   = r_u - 12'(r_dx);
    end
    if (32'(r_us) >= UnitsMax) begin
      r_us = '0;
    end
    if (32'(r_rows) >= HISTORY_ROWS) begin
      r_rows = r_rows - 6'(HISTORY_ROWS);
    end
    if (6'(r_op_q.slot) >= r_rows) begin
      r_src_slot = SW'(6'(r_op_q.slot) - r_rows);
    end else begin
      r_src_slot = SW'(6'(r_op_q.slot) + 6'(HISTORY_ROWS) - r_rows);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (en) begin
      r_valid_q <= x_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_op_q <= x_op;
    end
  end

  // ---------------------------------------------------------------------------
  // Data stage: resolve unit, write back, track filled prefix per row slot
  logic          d_valid_q;
  hop_t          d_op_q;
  logic [SW-1:0] d_src_slot_q;
  logic [UW-1:0] d_src_us_q;
  logic [15:0]   hist_rd, d_unit, unit0_q;
  logic [FW-1:0] fill_q [HISTORY_ROWS];
  logic          lw_valid_q;
  logic [HistAw-1:0] lw_addr_q;
  logic [15:0]   lw_data_q;
  logic          d_hit, d_fwd, d_wr;
  logic [FW-1:0] d_unit_end;

  magd_hist_mem #(
    .Depth(HistDepth),
    .AddrW(HistAw)
  ) u_hist_mem (
    .clk_i    (clk_i),
    .wr_en_i  (d_wr),
    .wr_addr_i({d_op_q.slot, d_op_q.unit}),
    .wr_data_i(d_unit),
    .rd_en_i  (en),
    .rd_addr_i({r_src_slot, r_us[UW-1:0]}),
    .rd_data_o(hist_rd)
  );

  always_comb begin
    d_hit      = {1'b0, d_src_us_q} < fill_q[d_src_slot_q];
    d_fwd      = lw_valid_q && (lw_addr_q == {d_src_slot_q, d_src_us_q});
    d_unit_end = FW'(d_op_q.unit) + FW'(1);
    d_wr       = en && d_valid_q && (32'(d_op_q.unit) < UnitsMax);
    if (d_op_q.lit) begin
      d_unit = d_op_q.lit_val;
    end else if (d_op_q.clr) begin
      d_unit = 16'h0000;
    end else if (d_fwd) begin
      d_unit = lw_data_q;
    end else if (d_hit) begin
      d_unit = hist_rd;
    end else begin
      d_unit = 16'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q  <= 1'b0;
      lw_valid_q <= 1'b0;
      for (int i = 0; i < HISTORY_ROWS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (en) begin
      d_valid_q <= r_valid_q;
      if (d_valid_q) begin
        lw_valid_q <= d_wr;
        // image start drops all earlier rows; own write extends its slot
        for (int i = 0; i < HISTORY_ROWS; i++) begin
          if (d_wr && (32'(d_op_q.slot) == i) &&
              (d_op_q.clr || (d_unit_end > fill_q[i]))) begin
            fill_q[i] <= d_unit_end;
          end else if (d_op_q.clr) begin
            fill_q[i] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_op_q       <= r_op_q;
      d_src_slot_q <= r_src_slot;
      d_src_us_q   <= r_us[UW-1:0];
      if (d_valid_q) begin
        lw_addr_q <= {d_op_q.slot, d_op_q.unit};
        lw_data_q <= d_unit;
        if (!d_op_q.last) begin
          unit0_q <= d_unit;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  logic [31:0] out_pix_q;
  logic [2:0]  out_used_q;
  logic        out_row_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid_q && d_op_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && d_valid_q && d_op_q.last) begin
      out_pix_q     <= {unit0_q, d_unit};
      out_used_q    <= d_op_q.used;
      out_row_end_q <= d_op_q.row_done;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign pixel_units_o        = out_pix_q;
  assign literal_bytes_used_o = out_used_q;
  assign row_end_o            = out_row_end_q;

endmodule

[hdl/magd_flag_mem.sv]
// Flag row store: one flag byte per column in a synchronous RAM.
// Per-column valid bits make cleared columns read as zero. No dependencies.
module magd_flag_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i
);

  logic [7:0]       mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic [7:0]       rd_data_q;
  logic             rd_vld_q;

  // Storage array and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits; a clear wins over an older valid entry on the same read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i] & ~clr_i;
      end
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : 8'h00;

endmodule

[hdl/magd_hist_mem.sv]
// Unit history RAM: one write port, one read port, read data registered.
// Read during write to the same entry returns the old data. No dependencies.
module magd_hist_mem #(
  parameter int unsigned Depth = 8704,
  parameter int unsigned AddrW = 14
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [15:0]      wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [15:0]      rd_data_o
);

  logic [15:0] mem_q [Depth];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[tb/mag_decoder_checker.sv]
// Checker for the MAG pixel decoder: watches input and output transactions,
// predicts each result with its own flag row and unit history, compares fields.
// Depends on magd_pkg.
module mag_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        image_first_i,
  input  logic        flag_a_bit_i,
  input  logic [7:0]  flag_b_byte_i,
  input  logic [31:0] literal_window_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] pixel_units_i,
  input  logic [2:0]  literal_bytes_used_i,
  input  logic        row_end_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import magd_pkg::*;

  localparam int UnitsMax = 512;
  localparam int ColsMax  = 256;
  localparam int HistRows = 17;

  typedef struct packed {
    logic [31:0] units;
    logic [2:0]  used;
    logic        row_end;
  } pix_result_t;

  pix_result_t expected_pixels[$];
  logic        mode_256;
  logic [9:0]  x_lo, x_hi;
  logic [7:0]  flags[ColsMax];
  logic [15:0] history[HistRows*UnitsMax];
  int          column, row_slot;

  function automatic int flag_cols();
    int w;
    w = ((((x_hi >> 3) - (x_lo >> 3)) & 127) + 1) * 8;
    if (w > 1024) w = 1024;
    return mode_256 ? (w >> 2) : (w >> 3);
  endfunction

  // Copy source: row and unit offsets, walking back into earlier rows as needed
  function automatic logic [15:0] copy_unit(logic [3:0] nib, int u, int upr);
    int rows, dx, us, extra;
    rows = int'(back_rows(nib));
    dx   = int'(back_units(nib));
    if (dx > u) begin
      extra = (dx - u + upr - 1) / upr;
      rows += extra;
      us = u + extra * upr - dx;
    end else begin
      us = u - dx;
    end
    if (us >= UnitsMax) us = 0;
    rows = rows % HistRows;
    return history[((row_slot + HistRows - rows) % HistRows) * UnitsMax + us];
  endfunction

  task automatic decode_column(logic first, logic fa, logic [7:0] fb, logic [31:0] win);
    int cols, upr, u, used;
    logic [7:0] flag;
    logic [3:0] nib;
    logic [15:0] val[2];
    pix_result_t r;
    if (first) begin
      foreach (flags[i]) flags[i] = '0;
      foreach (history[i]) history[i] = '0;
      column = 0;
      row_slot = 0;
    end
    cols = flag_cols();
    upr = cols * 2;
    used = 0;
    if (column >= cols) column = 0;
    if (fa) flags[column] ^= fb;
    flag = flags[column];
    for (int n = 0; n < 2; n++) begin
      nib = n == 0 ? flag[7:4] : flag[3:0];
      u = column * 2 + n;
      if (nib == 4'h0) begin
        val[n] = used == 0 ? win[31:16] : win[15:0];
        used += 2;
      end else begin
        val[n] = copy_unit(nib, u, upr);
      end
      if (u < UnitsMax) history[row_slot * UnitsMax + u] = val[n];
    end
    r.units = {val[0], val[1]};
    r.used = 3'(used);
    r.row_end = column + 1 >= cols;
    if (r.row_end) begin
      column = 0;
      row_slot = (row_slot + 1) % HistRows;
    end else begin
      column++;
    end
    expected_pixels = {expected_pixels, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_result_t e;
    if (!rst_ni) begin
      mode_256 = 1'b0;
      x_lo = XStartRst;
      x_hi = XEndRst;
      foreach (flags[i]) flags[i] = '0;
      foreach (history[i]) history[i] = '0;
      column = 0;
      row_slot = 0;
      fail_count_o = 0;
      checked_o = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_COLOR_MODE: mode_256 = cfg_wdata_i[0];
          CFG_X_START:    x_lo = cfg_wdata_i;
          CFG_X_END:      x_hi = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        decode_column(image_first_i, flag_a_bit_i, flag_b_byte_i, literal_window_i);
      // Output transaction compare
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result units=%h", $realtime, pixel_units_i);
          fail_count_o++;
        end else begin
          e = expected_pixels.pop_front();
          if (e.units !== pixel_units_i) begin
            $display("%0t: pixel_units exp %h got %h", $realtime, e.units, pixel_units_i);
            fail_count_o++;
          end
          if (e.used !== literal_bytes_used_i) begin
            $display("%0t: literal_bytes_used exp %0d got %0d", $realtime, e.used,
                     literal_bytes_used_i);
            fail_count_o++;
          end
          if (e.row_end !== row_end_i) begin
            $display("%0t: row_end exp %b got %b", $realtime, e.row_end, row_end_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_pixels.size();
  end
endmodule

[tb/tb.sv]
// Testbench top for the MAG pixel decoder: clock, reset, config phases,
// directed and random flag columns, bursty sender and stalling receiver.
// Depends on magd_pkg, mag_image_flag_copy_decoder and mag_decoder_checker.
module tb;
  import magd_pkg::*;

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = '0;
  logic [9:0]  cfg_wdata = '0;
  logic        in_valid = 0, in_ready;
  logic        image_first = 0, flag_a_bit = 0;
  logic [7:0]  flag_b_byte = '0;
  logic [31:0] literal_window = '0;
  logic        out_valid, out_ready = 0;
  logic [31:0] pixel_units;
  logic [2:0]  literal_bytes_used;
  logic        row_end;
  int          fail_count, pending, checked;
  int          cycles = 0;
  int          stall_mode = 0;
  int          sent = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  mag_image_flag_copy_decoder DUT (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .image_first_i(image_first),
    .flag_a_bit_i(flag_a_bit), .flag_b_byte_i(flag_b_byte),
    .literal_window_i(literal_window), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pixel_units_o(pixel_units), .literal_bytes_used_o(literal_bytes_used),
    .row_end_o(row_end)
  );

  mag_decoder_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .image_first_i(image_first),
    .flag_a_bit_i(flag_a_bit), .flag_b_byte_i(flag_b_byte),
    .literal_window_i(literal_window), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .pixel_units_i(pixel_units), .literal_bytes_used_i(literal_bytes_used),
    .row_end_i(row_end), .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked)
  );

  // Receiver stall pattern: mode 0 never stalls, others stall at varying rates
  always @(posedge clk_i) begin
    case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= cycles[2];
    endcase
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [9:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 0;
  endtask

  // Let the checker record the last transaction before looking at the count
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One column transaction; valid held until accepted, optional gap after
  task automatic send_column(logic first, logic fa, logic [7:0] fb, logic [31:0] win,
                             int gap);
    in_valid <= 1;
    image_first <= first;
    flag_a_bit <= fa;
    flag_b_byte <= fb;
    literal_window <= win;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Bursty random image: mostly deep copy flags, some literal and noise
  task automatic random_image(int count);
    int burst, gap;
    logic [7:0] fb;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) burst = $urandom_range(1, 12);
      burst--;
      gap = (burst == 0 && $urandom_range(0, 1)) ? $urandom_range(1, 6) : 0;
      fb = 8'($urandom);
      if ($urandom_range(0, 3) == 0) fb[7:4] = 4'h0;
      send_column(i == 0, $urandom_range(0, 2) != 0, fb, $urandom, gap);
    end
    in_valid <= 0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: defaults, literals, every copy nibble, field extremes
    send_column(1, 0, 8'h00, 32'hffff_ffff, 0);
    send_column(0, 1, 8'hff, 32'h0000_0000, 0);
    send_column(0, 1, 8'h0f, 32'h1234_5678, 1);
    send_column(0, 1, 8'hf0, 32'h8000_0001, 0);
    for (int v = 1; v < 16; v++)
      send_column(0, 1, 8'(v << 4) ^ 8'(v), 32'hdead_0000 | v, 0);
    send_column(0, 0, 8'h55, 32'haaaa_5555, 0);
    in_valid <= 0;
    drain();

    // Smallest rows, 16 colors: exercise row wrap and multi-row copies
    write_reg(CFG_COLOR_MODE, 10'd0);
    write_reg(CFG_X_START, 10'd1023);
    write_reg(CFG_X_END, 10'd1023);
    random_image(100);
    drain();

    // Wrapped range and 256 colors, wide
    write_reg(CFG_COLOR_MODE, 10'd1);
    write_reg(CFG_X_START, 10'd40);
    write_reg(CFG_X_END, 10'd7);
    random_image(100);
    drain();

    write_reg(CFG_X_START, 10'd0);
    write_reg(CFG_X_END, 10'd23);
    random_image(120);
    drain();

    // Widest row in 256 colors, then shrink mid-image to force column restart
    write_reg(CFG_X_END, 10'd1023);
    random_image(100);
    drain();
    write_reg(CFG_COLOR_MODE, 10'd0);
    write_reg(CFG_X_END, 10'd15);
    for (int i = 0; i < 80; i++)
      send_column(0, 1'($urandom_range(0, 1)), 8'($urandom), $urandom,
                  $urandom_range(0, 2));
    in_valid <= 0;
    drain();

    $display("Covered %0d column transactions, %0d results, over 16/256 colors", sent,
             checked);
    $display("and row widths from 8 to 1024 pixels, including a wrapped range.");
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
